FILE: rtl/pida_pkg.sv
// pida_pkg: shared types and codes for the positional insert/delete array
// depends on nothing; used by the cell and the top level
`timescale 1ns / 1ps

package pida_pkg;

    // width of position/count compares inside the cell row, covers depth up to 1024
    localparam int CTL_BITS = 11;

    typedef enum logic [2:0] {
        CMD_INSERT = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_READ   = 3'd2,
        CMD_WRITE  = 3'd3,
        CMD_SEARCH = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd               cmd;
        logic signed [31:0] value;
        logic [6:0]         position;
    } t_cmd_req;

    typedef struct packed {
        logic signed [31:0] read_data;
        logic               found;
        logic [6:0]         entry_count;
        t_status            status;
    } t_rsp;

    // broadcast to every cell in the row
    typedef struct packed {
        logic                act;   // command accepted and legal, cells may update
        t_cmd                cmd;
        logic [CTL_BITS-1:0] pos;
        logic [CTL_BITS-1:0] count;
    } t_cell_ctl;

endpackage

FILE: rtl/pida_stream_if.sv
// pida_stream_if: valid/ready channel carrying one payload of type T
// depends on nothing; payload types come from pida_pkg at the instance
`timescale 1ns / 1ps

interface pida_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/pida_cell.sv
// pida_cell: one storage slot of the array, shifts with its neighbors
// depends on pida_pkg
`timescale 1ns / 1ps

module pida_cell #(
    parameter int INDEX     = 0,
    parameter int WORD_BITS = 32
) (
    input  logic                   i_clk,
    input  pida_pkg::t_cell_ctl    i_ctl,
    input  logic [WORD_BITS-1:0]   i_value,
    input  logic [WORD_BITS-1:0]   i_left,
    input  logic [WORD_BITS-1:0]   i_right,
    output logic [WORD_BITS-1:0]   o_word,
    output logic [WORD_BITS-1:0]   o_read,
    output logic                   o_match
);

    localparam logic [pida_pkg::CTL_BITS-1:0] IDX = pida_pkg::CTL_BITS'(INDEX);
    localparam logic [pida_pkg::CTL_BITS-1:0] IDX_NEXT = pida_pkg::CTL_BITS'(INDEX + 1);

    logic [WORD_BITS-1:0] r_word;
    logic [WORD_BITS-1:0] n_word;
    logic                 at_pos;

    assign at_pos = (IDX == i_ctl.pos);

    always_comb begin
        n_word = r_word;
        if (i_ctl.act) begin
            unique case (i_ctl.cmd)
                pida_pkg::CMD_INSERT: begin
                    if (at_pos) begin
                        n_word = i_value;
                    end else if (IDX > i_ctl.pos && IDX <= i_ctl.count) begin
                        n_word = i_left;
                    end
                end
                pida_pkg::CMD_REMOVE: begin
                    if (IDX >= i_ctl.pos && IDX_NEXT < i_ctl.count) begin
                        n_word = i_right;
                    end
                end
                pida_pkg::CMD_WRITE: begin
                    if (at_pos) begin
                        n_word = i_value;
                    end
                end
                default: begin
                    n_word = r_word;
                end
            endcase
        end
    end

    // payload only, no reset: a slot is live only after an insert wrote it
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word  = r_word;
    assign o_read  = at_pos ? r_word : '0;
    assign o_match = (IDX < i_ctl.count) && (r_word == i_value);

endmodule

FILE: rtl/positional_insert_delete_array_core.sv
// positional_insert_delete_array_core: bounded ordered array with insert/remove at index
// depends on pida_pkg, pida_stream_if and pida_cell
//
//  channel | dir | payload                                   | accepted when
//  i_cmd   | in  | cmd, value, position                      | valid && ready
//  o_rsp   | out | read_data, found, entry_count, status     | valid && ready
//
// one request per cycle while responses are taken: the row of cells shifts, loads and compares in parallel,
// so a legal request updates every affected slot in the cycle it is accepted
// the response sits in a single output register and shows in the cycle after acceptance
// a stalled response blocks new requests only while it is still held
// reset clears the live count and the response valid; slot contents are not cleared
// no request is taken while reset is asserted
`timescale 1ns / 1ps

module positional_insert_delete_array_core #(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    pida_stream_if.sink   i_cmd,
    pida_stream_if.source o_rsp
);

    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam int CB       = pida_pkg::CTL_BITS;
    localparam logic [CB-1:0] DEPTH_X = CB'(DEPTH);

    // live count and response register
    logic [CNT_BITS-1:0] r_count;
    logic [CNT_BITS-1:0] n_count;
    logic                r_rsp_valid;
    pida_pkg::t_rsp      r_rsp;
    pida_pkg::t_rsp      n_rsp;

    logic                accept;
    pida_pkg::t_cmd_req  req;
    pida_pkg::t_cell_ctl ctl;
    pida_pkg::t_status   status;
    logic [CB-1:0]       pos_x;
    logic [CB-1:0]       cnt_x;

    // input word sign-extended then cut to the stored width
    logic signed [63:0]   value_ext;
    logic [WORD_BITS-1:0] value_w;

    // cell row wiring
    logic [WORD_BITS-1:0] w_word [DEPTH];
    logic [WORD_BITS-1:0] w_read [DEPTH];
    logic [DEPTH-1:0]     w_match;

    logic [WORD_BITS-1:0] read_or;
    logic signed [63:0]   read_ext;

    assign req     = i_cmd.data;
    // output register parts the sides: take a request whenever the slot frees up
    assign i_cmd.ready = i_rst_n && (!r_rsp_valid || o_rsp.ready);
    assign accept  = i_cmd.valid && i_cmd.ready;

    assign value_ext = 64'(req.value);
    assign value_w   = value_ext[WORD_BITS-1:0];

    assign pos_x = CB'(req.position);
    assign cnt_x = CB'(r_count);

    // bounds checks, count update
    always_comb begin
        status  = pida_pkg::ST_OK;
        n_count = r_count;
        unique case (req.cmd)
            pida_pkg::CMD_INSERT: begin
                priority if (cnt_x == DEPTH_X) begin
                    status = pida_pkg::ST_FULL;
                end else if (pos_x > cnt_x) begin
                    status = pida_pkg::ST_RANGE;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            pida_pkg::CMD_REMOVE: begin
                if (pos_x >= cnt_x) begin
                    status = pida_pkg::ST_RANGE;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            pida_pkg::CMD_READ, pida_pkg::CMD_WRITE: begin
                if (pos_x >= cnt_x) begin
                    status = pida_pkg::ST_RANGE;
                end
            end
            default: begin
                status = pida_pkg::ST_OK;
            end
        endcase
    end

    // broadcast to the row; illegal requests leave every slot alone
    always_comb begin
        ctl.act   = accept && (status == pida_pkg::ST_OK);
        ctl.cmd   = req.cmd;
        ctl.pos   = pos_x;
        ctl.count = cnt_x;
    end

    // row of cells: insert pulls from the left neighbor, remove from the right
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WORD_BITS-1:0] left_w;
        logic [WORD_BITS-1:0] right_w;

        if (g == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_mid_l
            assign left_w = w_word[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_mid_r
            assign right_w = w_word[g+1];
        end

        pida_cell #(
            .INDEX     (g),
            .WORD_BITS (WORD_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_value (value_w),
            .i_left  (left_w),
            .i_right (right_w),
            .o_word  (w_word[g]),
            .o_read  (w_read[g]),
            .o_match (w_match[g])
        );
    end

    // only the addressed cell drives nonzero read data, so an or collects it
    always_comb begin
        read_or = '0;
        for (int k = 0; k < DEPTH; k++) begin
            read_or = read_or | w_read[k];
        end
    end

    assign read_ext = 64'(signed'(read_or));

    always_comb begin
        n_rsp.read_data   = '0;
        n_rsp.found       = 1'b0;
        n_rsp.entry_count = 7'(n_count);
        n_rsp.status      = status;
        if (req.cmd == pida_pkg::CMD_READ && status == pida_pkg::ST_OK) begin
            n_rsp.read_data = read_ext[31:0];
        end
        if (req.cmd == pida_pkg::CMD_SEARCH) begin
            n_rsp.found = |w_match;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
            end
            if (accept) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // response payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.data  = r_rsp;

endmodule
